>>> hdl/ispsq_pkg.sv
// Package for the idle/sleep/stop power sequencer.
// Holds item and state types, operation codes, mode codes and constants.
// No dependencies.
package ispsq_pkg;

  localparam int unsigned TaskW      = 7;
  localparam int unsigned NumTasks   = 7;
  localparam int unsigned TickW      = 32;
  localparam int unsigned ModeW      = 3;
  localparam int unsigned CfgIdxW    = 1;
  localparam logic [TickW-1:0] DefaultTimeout = 32'd30000;
  localparam logic [TaskW-1:0] UiTaskBit      = 7'h01;

  typedef enum logic [1:0] {
    OP_STEP     = 2'd0,
    OP_ACTIVITY = 2'd1,
    OP_WAKE     = 2'd2,
    OP_CONSUME  = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IDLE_TIMEOUT = 1'b0,
    CFG_DEEP_TIMEOUT = 1'b1
  } cfg_idx_e;

  localparam logic [ModeW-1:0] ModeActive    = 3'd0;
  localparam logic [ModeW-1:0] ModePrepSleep = 3'd1;
  localparam logic [ModeW-1:0] ModeSleeping  = 3'd2;
  localparam logic [ModeW-1:0] ModePrepStop  = 3'd3;
  localparam logic [ModeW-1:0] ModeStop      = 3'd4;
  localparam logic [ModeW-1:0] ModeWakeup    = 3'd5;

  typedef struct packed {
    logic [1:0]       operation;
    logic [TickW-1:0] now_tick;
    logic [TaskW-1:0] running_tasks;
    logic             alarm_ringing;
    logic             wake_is_key;
  } in_item_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic             cpu_sleep_req;
    logic             stop_req;
    logic             clock_restore;
    logic [TaskW-1:0] resume_tasks;
    logic [TaskW-1:0] suspend_tasks;
    logic             motion_armed;
    logic             discard_key;
  } out_item_t;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [TickW-1:0] last_active;
    logic [TickW-1:0] sleep_start;
    logic             wake_pending;
    logic             discard_pending;
    logic [TaskW-1:0] held_tasks;
    logic             motion_flag;
    logic             from_stop;
  } seq_state_t;

endpackage

>>> hdl/ispsq_if.sv
// Stream interfaces for the power sequencer's event and result channels.
// Depends on ispsq_pkg for the payload types.
interface ispsq_in_if;
  logic                valid;
  logic                ready;
  ispsq_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ispsq_out_if;
  logic                 valid;
  logic                 ready;
  ispsq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/idle_sleep_stop_power_sequencer_core.sv
// Top level of the idle/sleep/stop power sequencer.
// Depends on ispsq_pkg, ispsq_in_if, ispsq_out_if and ispsq_step.
//
// Usage:
//   Events enter on in_i (valid/ready); each transfer carries an operation,
//   the current tick and the task/alarm/key sample. Every event yields exactly
//   one result on out_o: the mode after the event plus the request strobes
//   and task masks for that step.
//   Timeouts are written through cfg_we_i/cfg_idx_i/cfg_wdata_i: index 0 is
//   the idle timeout, index 1 the deep timeout. Write them only while idle.
//   An event taken from in_i waits in the input register while the step logic
//   evaluates it; its result goes to the result register and out_o (one
//   input register, one result register). Throughput: one event per cycle while
//   out_o accepts; the sequencer state register is updated as the event leaves
//   the input register, so back-to-back events see each other's effect.
//   When out_o stalls, the result register holds, the input register holds
//   its event, and in_i.ready drops once both are full.
//   Reset returns to active mode with all state cleared and both timeouts
//   at 30000 ticks; no results are pending after reset.
module idle_sleep_stop_power_sequencer_core #(
  parameter int unsigned NUM_TASKS = ispsq_pkg::NumTasks
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ispsq_in_if.sink                      in_i,
  ispsq_out_if.source                   out_o,
  input  logic                          cfg_we_i,
  input  logic [ispsq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ispsq_pkg::TickW-1:0]   cfg_wdata_i
);

  logic                         stg_v_q;
  ispsq_pkg::in_item_t          stg_q;
  logic                         out_v_q;
  ispsq_pkg::out_item_t         out_q;
  ispsq_pkg::seq_state_t        state_q;
  ispsq_pkg::seq_state_t        state_d;
  ispsq_pkg::out_item_t         result_d;
  logic [ispsq_pkg::TickW-1:0]  idle_to_q;
  logic [ispsq_pkg::TickW-1:0]  deep_to_q;
  logic                         adv;
  logic                         take;

  assign adv       = !out_v_q || out_o.ready;
  assign take      = stg_v_q && adv;
  assign in_i.ready = !stg_v_q || adv;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  ispsq_step #(
    .NUM_TASKS (NUM_TASKS)
  ) u_step (
    .state_i   (state_q),
    .item_i    (stg_q),
    .idle_to_i (idle_to_q),
    .deep_to_i (deep_to_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_to_q <= ispsq_pkg::DefaultTimeout;
      deep_to_q <= ispsq_pkg::DefaultTimeout;
    end else if (cfg_we_i) begin
      case (ispsq_pkg::cfg_idx_e'(cfg_idx_i))
        ispsq_pkg::CFG_IDLE_TIMEOUT: idle_to_q <= cfg_wdata_i;
        ispsq_pkg::CFG_DEEP_TIMEOUT: deep_to_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      out_v_q <= 1'b0;
      state_q <= '0;
    end else begin
      if (in_i.ready) stg_v_q <= in_i.valid;
      if (adv) out_v_q <= stg_v_q;
      if (take) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) stg_q <= in_i.data;
    if (take) out_q <= result_d;
  end

  a_take_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> out_v_q)
    else $error("taken event did not reach result register");

  a_stop_goes_wakeup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.stop_req) |-> (out_q.mode == ispsq_pkg::ModeWakeup && out_q.motion_armed))
    else $error("stop request without wakeup and motion arm");

  a_wfi_in_sleep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.cpu_sleep_req) |-> (out_q.mode == ispsq_pkg::ModeSleeping))
    else $error("sleep request outside sleeping mode");

  a_restore_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.clock_restore) |-> (out_q.mode == ispsq_pkg::ModeActive &&
                                          !out_q.motion_armed))
    else $error("clock restore outside wake to active");

  a_mode_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode <= ispsq_pkg::ModeWakeup)
    else $error("mode register left valid range");

endmodule

>>> hdl/ispsq_step.sv
// Next-state and result logic for one sequencer event.
// Depends on ispsq_pkg for types, operation codes and mode codes.
module ispsq_step #(
  parameter int unsigned NUM_TASKS = ispsq_pkg::NumTasks
) (
  input  ispsq_pkg::seq_state_t          state_i,
  input  ispsq_pkg::in_item_t            item_i,
  input  logic [ispsq_pkg::TickW-1:0]    idle_to_i,
  input  logic [ispsq_pkg::TickW-1:0]    deep_to_i,
  output ispsq_pkg::seq_state_t          state_o,
  output ispsq_pkg::out_item_t           result_o
);

  localparam int unsigned MaskW = (NUM_TASKS < ispsq_pkg::TaskW) ? NUM_TASKS : ispsq_pkg::TaskW;
  localparam logic [ispsq_pkg::TaskW-1:0] TaskMask =
    ispsq_pkg::TaskW'((64'd1 << MaskW) - 64'd1);

  logic [ispsq_pkg::TickW-1:0] idle_dt;
  logic [ispsq_pkg::TickW-1:0] sleep_dt;
  logic                        low_power;

  assign idle_dt   = item_i.now_tick - state_i.last_active;
  assign sleep_dt  = item_i.now_tick - state_i.sleep_start;
  assign low_power = (state_i.mode == ispsq_pkg::ModeSleeping) ||
                     (state_i.mode == ispsq_pkg::ModePrepStop) ||
                     (state_i.mode == ispsq_pkg::ModeStop);

  always_comb begin
    ispsq_pkg::seq_state_t s;
    ispsq_pkg::out_item_t  r;
    s = state_i;
    r = '0;
    case (ispsq_pkg::op_e'(item_i.operation))
      ispsq_pkg::OP_STEP: begin
        case (state_i.mode)
          ispsq_pkg::ModeActive: begin
            if (idle_dt >= idle_to_i) s.mode = ispsq_pkg::ModePrepSleep;
          end
          ispsq_pkg::ModePrepSleep: begin
            s.held_tasks   = item_i.running_tasks & TaskMask;
            r.suspend_tasks = item_i.running_tasks & TaskMask;
            s.motion_flag  = 1'b1;
            s.wake_pending = 1'b0;
            s.sleep_start  = item_i.now_tick;
            s.mode         = ispsq_pkg::ModeSleeping;
          end
          ispsq_pkg::ModeSleeping: begin
            if (state_i.wake_pending) begin
              s.wake_pending = 1'b0;
              s.mode         = ispsq_pkg::ModeWakeup;
            end else if (sleep_dt >= deep_to_i) begin
              s.mode = ispsq_pkg::ModePrepStop;
            end else begin
              r.cpu_sleep_req = 1'b1;
            end
          end
          ispsq_pkg::ModePrepStop: begin
            s.motion_flag  = 1'b1;
            s.from_stop    = 1'b1;
            s.wake_pending = 1'b1;
            r.stop_req     = 1'b1;
            s.mode         = ispsq_pkg::ModeWakeup;
          end
          ispsq_pkg::ModeStop: begin
            s.mode = ispsq_pkg::ModeWakeup;
          end
          ispsq_pkg::ModeWakeup: begin
            s.last_active   = item_i.now_tick;
            r.clock_restore = state_i.from_stop;
            s.from_stop     = 1'b0;
            s.motion_flag   = 1'b0;
            if (!item_i.alarm_ringing) begin
              r.resume_tasks = (state_i.held_tasks != '0) ? state_i.held_tasks
                                                          : (ispsq_pkg::UiTaskBit & TaskMask);
              s.held_tasks   = '0;
            end
            s.mode = ispsq_pkg::ModeActive;
          end
          default: begin
            s.mode = ispsq_pkg::ModeActive;
          end
        endcase
      end
      ispsq_pkg::OP_ACTIVITY: begin
        s.last_active = item_i.now_tick;
        if (low_power) s.wake_pending = 1'b1;
      end
      ispsq_pkg::OP_WAKE: begin
        s.last_active  = item_i.now_tick;
        if (item_i.wake_is_key && low_power) s.discard_pending = 1'b1;
        s.wake_pending = 1'b1;
      end
      default: begin
        r.discard_key     = state_i.discard_pending;
        s.discard_pending = 1'b0;
      end
    endcase
    r.mode         = s.mode;
    r.motion_armed = s.motion_flag;
    state_o  = s;
    result_o = r;
  end

endmodule
